>>> rtl/blt_pkg.sv
`default_nettype none
package blt_pkg;

	// Coordinate fields, registers and the divider are sized from this
	localparam int CW = 12;
	// Width of the scaled numerator (d + offset) * (span - 1) and of its quotient
	localparam int NW = 2 * CW + 1;
	localparam int TEX_DEPTH_DEF = 4096;
	localparam int FIFO_DEPTH = 4;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_TINT        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_SIZE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CROP_ORIGIN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPAN_SIZE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DEST_FULL   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DEST_OFFSET = 3'd5;

	localparam logic FUNC_LOAD   = 1'b0;
	localparam logic FUNC_RENDER = 1'b1;

	localparam logic [31:0] TINT_RST  = 32'hFFFF_FFFF;
	localparam logic [23:0] IMAGE_RST = 24'd4097;

	typedef struct packed {
		logic        func;
		logic [11:0] texel_addr;
		logic [31:0] texel_rgba;
		logic [11:0] dst_x;
		logic [11:0] dst_y;
		logic [7:0]  dst_b;
		logic [7:0]  dst_g;
		logic [7:0]  dst_r;
	} in_t;

	typedef struct packed {
		logic [7:0] out_b;
		logic [7:0] out_g;
		logic [7:0] out_r;
	} out_t;

	typedef struct packed {
		logic [31:0] tint;
		logic [23:0] image_size;
		logic [23:0] crop_origin;
		logic [23:0] span_size;
		logic [23:0] dest_full_size;
		logic [23:0] dest_offset;
	} cfg_t;

	typedef struct packed {
		logic [7:0] b;
		logic [7:0] g;
		logic [7:0] r;
	} color_t;

	// Fields that ride along with the divider
	typedef struct packed {
		logic        func;
		logic [11:0] texel_addr;
		logic [31:0] texel_rgba;
		logic        zero_x;
		logic        zero_y;
		color_t      color;
	} tail_t;

	typedef struct packed {
		tail_t          tail;
		logic [NW-1:0]  num_x;
		logic [NW-1:0]  num_y;
		logic [CW-1:0]  div_x;
		logic [CW-1:0]  div_y;
	} job_t;

	// Exact x / 255 for x below 65280
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [15:0] t;
		t = x + {8'd0, x[15:8]} + 16'd1;
		return t[15:8];
	endfunction

	function automatic logic [7:0] tint_mul(input logic [7:0] v, input logic [7:0] m);
		logic [15:0] p;
		p = ({8'd0, v} * {8'd0, m}) + 16'd127;
		return div255(p);
	endfunction

	function automatic logic [7:0] mix(input logic [7:0] s, input logic [7:0] d,
			input logic [7:0] a);
		logic [15:0] p;
		p = ({8'd0, s} * {8'd0, a}) + ({8'd0, d} * {8'd0, 8'd255 - a}) + 16'd127;
		return div255(p);
	endfunction

endpackage
`default_nettype wire

>>> rtl/blt_ram.sv
`default_nettype none
module blt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

>>> rtl/blt_front.sv
`default_nettype none
module blt_front import blt_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	input  wire in_t  item,
	input  wire cfg_t cfg,
	input  wire logic almost_full,
	output logic      push,
	output job_t      job
);

	logic v_s1;
	in_t  item_s1;

	logic [CW:0]   sum_x, sum_y;
	logic [CW-1:0] span_x, span_y, full_x, full_y;

	assign busy = almost_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			item_s1 <= item;
		end
	end

	// Mapping numerator (one multiply), divisor and zero flag
	always_comb begin
		span_x = cfg.span_size[CW-1:0];
		span_y = cfg.span_size[2*CW-1:CW];
		full_x = cfg.dest_full_size[CW-1:0];
		full_y = cfg.dest_full_size[2*CW-1:CW];
		sum_x  = {1'b0, item_s1.dst_x} + {1'b0, cfg.dest_offset[CW-1:0]};
		sum_y  = {1'b0, item_s1.dst_y} + {1'b0, cfg.dest_offset[2*CW-1:CW]};

		job.num_x = NW'(sum_x * (span_x - CW'(1)));
		job.num_y = NW'(sum_y * (span_y - CW'(1)));
		job.div_x = full_x - CW'(1);
		job.div_y = full_y - CW'(1);

		job.tail.func       = item_s1.func;
		job.tail.texel_addr = item_s1.texel_addr;
		job.tail.texel_rgba = item_s1.texel_rgba;
		job.tail.zero_x     = (full_x <= CW'(1)) || (span_x == '0);
		job.tail.zero_y     = (full_y <= CW'(1)) || (span_y == '0);
		job.tail.color.b    = item_s1.dst_b;
		job.tail.color.g    = item_s1.dst_g;
		job.tail.color.r    = item_s1.dst_r;
	end

	assign push = v_s1;

endmodule
`default_nettype wire

>>> rtl/blt_fifo.sv
`default_nettype none
module blt_fifo import blt_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire job_t wr_job,
	input  wire logic pop,
	output job_t      rd_job,
	output logic      not_empty,
	output logic      almost_full
);

	localparam int PW = $clog2(FIFO_DEPTH);

	job_t          mem_q [FIFO_DEPTH];
	logic [PW-1:0] wptr_q, rptr_q;
	logic [PW:0]   count_q;

	assign not_empty = count_q != '0;
	// Leave room for the transaction still in the front register
	assign almost_full = count_q >= (PW+1)'(FIFO_DEPTH - 2);
	assign rd_job = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + PW'(1);
			end
			if (pop) begin
				rptr_q <= rptr_q + PW'(1);
			end
			count_q <= count_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wr_job;
		end
	end

endmodule
`default_nettype wire

>>> rtl/blt_div.sv
`default_nettype none
module blt_div import blt_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire job_t          in_job,
	output logic               out_valid,
	output tail_t              out_tail,
	output logic [NW-1:0]      qx,
	output logic [NW-1:0]      qy
);

	logic          v_q   [NW];
	tail_t         tail_q[NW];
	logic [NW-1:0] nx_q  [NW];
	logic [NW-1:0] ny_q  [NW];
	logic [NW-1:0] qx_q  [NW];
	logic [NW-1:0] qy_q  [NW];
	logic [CW-1:0] rx_q  [NW];
	logic [CW-1:0] ry_q  [NW];
	logic [CW-1:0] dx_q  [NW];
	logic [CW-1:0] dy_q  [NW];

	// One restoring step per stage, both axes side by side
	for (genvar k = 0; k < NW; k++) begin : g_stage
		logic          vi;
		tail_t         ti;
		logic [NW-1:0] nxi, nyi, qxi, qyi;
		logic [CW-1:0] rxi, ryi, dxi, dyi;
		logic [CW:0]   tx, ty;
		logic          bx, by;

		if (k == 0) begin : g_first
			assign vi  = in_valid;
			assign ti  = in_job.tail;
			assign nxi = in_job.num_x;
			assign nyi = in_job.num_y;
			assign qxi = '0;
			assign qyi = '0;
			assign rxi = '0;
			assign ryi = '0;
			assign dxi = in_job.div_x;
			assign dyi = in_job.div_y;
		end else begin : g_next
			assign vi  = v_q[k-1];
			assign ti  = tail_q[k-1];
			assign nxi = nx_q[k-1];
			assign nyi = ny_q[k-1];
			assign qxi = qx_q[k-1];
			assign qyi = qy_q[k-1];
			assign rxi = rx_q[k-1];
			assign ryi = ry_q[k-1];
			assign dxi = dx_q[k-1];
			assign dyi = dy_q[k-1];
		end

		assign tx = {rxi, nxi[NW-1-k]};
		assign ty = {ryi, nyi[NW-1-k]};
		assign bx = tx >= {1'b0, dxi};
		assign by = ty >= {1'b0, dyi};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[k] <= 1'b0;
			end else begin
				v_q[k] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			tail_q[k] <= ti;
			nx_q[k]   <= nxi;
			ny_q[k]   <= nyi;
			dx_q[k]   <= dxi;
			dy_q[k]   <= dyi;
			rx_q[k]   <= bx ? CW'(tx - {1'b0, dxi}) : tx[CW-1:0];
			ry_q[k]   <= by ? CW'(ty - {1'b0, dyi}) : ty[CW-1:0];
			qx_q[k]   <= {qxi[NW-2:0], bx};
			qy_q[k]   <= {qyi[NW-2:0], by};
		end
	end

	assign out_valid = v_q[NW-1];
	assign out_tail  = tail_q[NW-1];
	assign qx        = qx_q[NW-1];
	assign qy        = qy_q[NW-1];

endmodule
`default_nettype wire

>>> rtl/blt_back.sv
`default_nettype none
module blt_back import blt_pkg::*; #(
	parameter int TEX_DEPTH = TEX_DEPTH_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire cfg_t          cfg,
	input  wire logic          in_valid,
	input  wire tail_t         in_tail,
	input  wire logic [NW-1:0] qx,
	input  wire logic [NW-1:0] qy,
	output logic               done,
	output out_t               result
);

	localparam int AW = $clog2(TEX_DEPTH);

	logic [NW-1:0] qx_eff, qy_eff;
	logic [NW:0]   sum_x, sum_y;
	logic [CW-1:0] w, h, sx, sy;

	logic          v_s1;
	tail_t         tail_s1;
	logic [CW-1:0] sx_s1, sy_s1, w_s1;

	logic [2*CW-1:0] row;
	logic [2*CW:0]   lin;
	logic [AW-1:0]   ram_addr;
	logic            ram_we;
	logic [31:0]     texel;

	logic   v_s2;
	color_t color_s2;

	logic       v_s3;
	color_t     color_s3;
	logic [7:0] a_s3, r_s3, g_s3, b_s3;

	logic done_q;
	out_t result_q;

	// Apply the zero-scale case, add the crop origin, clamp to the image edge
	always_comb begin
		qx_eff = in_tail.zero_x ? '0 : qx;
		qy_eff = in_tail.zero_y ? '0 : qy;
		w = (cfg.image_size[CW-1:0] == '0) ? CW'(1) : cfg.image_size[CW-1:0];
		h = (cfg.image_size[2*CW-1:CW] == '0) ? CW'(1) : cfg.image_size[2*CW-1:CW];
		sum_x = (NW+1)'(cfg.crop_origin[CW-1:0]) + (NW+1)'(qx_eff);
		sum_y = (NW+1)'(cfg.crop_origin[2*CW-1:CW]) + (NW+1)'(qy_eff);
		sx = (sum_x >= (NW+1)'(w)) ? w - CW'(1) : sum_x[CW-1:0];
		sy = (sum_y >= (NW+1)'(h)) ? h - CW'(1) : sum_y[CW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= in_valid;
			v_s2   <= v_s1 && (tail_s1.func == FUNC_RENDER);
			v_s3   <= v_s2;
			done_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		tail_s1 <= in_tail;
		sx_s1   <= sx;
		sy_s1   <= sy;
		w_s1    <= w;
	end

	// Loads write and renders read the texel store at the same point, so order holds
	always_comb begin
		row      = sy_s1 * w_s1;
		lin      = (2*CW+1)'(row) + (2*CW+1)'(sx_s1);
		ram_we   = v_s1 && (tail_s1.func == FUNC_LOAD);
		ram_addr = (tail_s1.func == FUNC_LOAD) ? AW'(tail_s1.texel_addr) : AW'(lin);
	end

	blt_ram #(
		.WIDTH(32),
		.DEPTH(TEX_DEPTH)
	) u_tex (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_addr),
		.wdata(tail_s1.texel_rgba),
		.raddr(ram_addr),
		.rdata(texel)
	);

	always_ff @(posedge clk) begin
		color_s2 <= tail_s1.color;
		color_s3 <= color_s2;
		a_s3     <= tint_mul(texel[31:24], cfg.tint[31:24]);
		r_s3     <= tint_mul(texel[7:0],   cfg.tint[23:16]);
		g_s3     <= tint_mul(texel[15:8],  cfg.tint[15:8]);
		b_s3     <= tint_mul(texel[23:16], cfg.tint[7:0]);
		result_q.out_b <= mix(b_s3, color_s3.b, a_s3);
		result_q.out_g <= mix(g_s3, color_s3.g, a_s3);
		result_q.out_r <= mix(r_s3, color_s3.r, a_s3);
	end

	assign done   = done_q;
	assign result = result_q;

endmodule
`default_nettype wire

>>> rtl/scaled_tinted_alpha_blit.sv
`default_nettype none
// Scaled, tinted alpha blit: one destination pixel per render transaction.
// Input channel: present an item on "item" with start high; it is taken at the
// rising edge where start is high and busy is low. func selects load (write
// texel_rgba to the texel store at texel_addr, no result) or render (map
// dst_x/dst_y into the source, fetch the texel, tint it and blend it over
// dst_b/dst_g/dst_r).
// Result channel: done is high for exactly one cycle with the blended pixel on
// "result"; the receiver cannot stall, so results never back up.
// Configuration: cfg_we, cfg_idx, cfg_wdata write one register per clock;
// write only while no render is in flight. Unknown indexes are ignored.
// Path: an accepted render is registered, queued and then mapped per coordinate
// by the one-bit-per-stage divider, followed by the clamp, address multiply,
// texel read, tint and blend.
// Throughput: one item per clock unless busy, load or render, in any mix.
// Reset: arst_n clears the pipeline and restores register defaults; the texel
// store holds no defined value until loaded. TEX_DEPTH must be a power of two.
module scaled_tinted_alpha_blit import blt_pkg::*; #(
	parameter int TEX_DEPTH = TEX_DEPTH_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire in_t                  item,
	output logic                      done,
	output out_t                      result,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [31:0]          cfg_wdata
);

	cfg_t cfg_q;

	logic          push;
	job_t          push_job;
	job_t          pop_job;
	logic          not_empty;
	logic          almost_full;
	logic          div_valid;
	tail_t         div_tail;
	logic [NW-1:0] qx, qy;

	// Register file: hold each value until rewritten
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tint           <= TINT_RST;
			cfg_q.image_size     <= IMAGE_RST;
			cfg_q.crop_origin    <= '0;
			cfg_q.span_size      <= '0;
			cfg_q.dest_full_size <= '0;
			cfg_q.dest_offset    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_TINT:        cfg_q.tint           <= cfg_wdata;
				REG_IMAGE_SIZE:  cfg_q.image_size     <= cfg_wdata[23:0];
				REG_CROP_ORIGIN: cfg_q.crop_origin    <= cfg_wdata[23:0];
				REG_SPAN_SIZE:   cfg_q.span_size      <= cfg_wdata[23:0];
				REG_DEST_FULL:   cfg_q.dest_full_size <= cfg_wdata[23:0];
				REG_DEST_OFFSET: cfg_q.dest_offset    <= cfg_wdata[23:0];
				default: ;
			endcase
		end
	end

	// Front: accept the transaction and build the mapping numerators
	blt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.item       (item),
		.cfg        (cfg_q),
		.almost_full(almost_full),
		.push       (push),
		.job        (push_job)
	);

	// Queue between front and back; the back drains one entry per clock
	blt_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.wr_job     (push_job),
		.pop        (not_empty),
		.rd_job     (pop_job),
		.not_empty  (not_empty),
		.almost_full(almost_full)
	);

	// Back: pipelined divide, then clamp, fetch, tint and blend
	blt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (not_empty),
		.in_job   (pop_job),
		.out_valid(div_valid),
		.out_tail (div_tail),
		.qx       (qx),
		.qy       (qy)
	);

	blt_back #(
		.TEX_DEPTH(TEX_DEPTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.in_valid(div_valid),
		.in_tail (div_tail),
		.qx      (qx),
		.qy      (qy),
		.done    (done),
		.result  (result)
	);

endmodule
`default_nettype wire
